### sv/ppbf_pkg.sv
// Package for the pcapng enhanced packet block framer.
// Holds payload structs, the front-to-back command type, the back-end state type
// and the block format constants. It depends on nothing else.
package ppbf_pkg;

  localparam int LEN_W       = 14;
  localparam int TOTAL_W     = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int DEF_MAX_PACKET_BYTES = 16384;

  // Block format constants
  localparam logic [31:0]        BLOCK_TYPE_EPB = 32'd6;
  localparam logic [15:0]        OPT_EPB_FLAGS  = 16'd2;
  localparam logic [15:0]        OPT_FLAGS_LEN  = 16'd4;
  localparam logic [TOTAL_W-1:0] BLOCK_OVERHEAD = TOTAL_W'(40);

  // Header is 28 bytes, trailer options and length are 12 bytes
  localparam logic [4:0] HDR_LAST_IDX = 5'd27;
  localparam logic [3:0] TRL_LAST_IDX = 4'd11;

  // Microsecond conversion: nsec / 1000 as (nsec * NS_RECIP) >> NS_SHIFT
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  localparam logic [30:0] NS_RECIP   = 31'd1099511628;
  localparam int          NS_SHIFT   = 40;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] decl_len;
    logic [15:0]      if_index;
    logic [31:0]      ts_seconds;
    logic [29:0]      ts_nanoseconds;
    logic [1:0]       direction;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_block;
  } out_item_t;

  // One classified input byte as handed from front to back
  typedef struct packed {
    logic             first;
    logic             last;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic [15:0]      ifid;
    logic [31:0]      sec;
    logic [29:0]      nsec;
    logic [1:0]       dir;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_FETCH,
    BK_HDR,
    BK_FIRST,
    BK_TRL
  } bk_state_t;

endpackage

### sv/ppbf_front.sv
// Front end of the framer: accepts packet bytes and classifies them.
// Tracks packet boundaries and pushes commands (cmd_t from ppbf_pkg) to the queue.
module ppbf_front #(
  parameter int MAX_PACKET_BYTES = ppbf_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  ppbf_pkg::in_item_t in_data,
  output logic              push,
  output ppbf_pkg::cmd_t    push_cmd
);

  logic                       in_packet_r, in_packet_nxt;
  logic [ppbf_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [ppbf_pkg::LEN_W-1:0] len_nz, len_clamped;
  logic                       last;

  // Declared length: zero means one byte, above the maximum saturates
  always_comb begin
    len_nz = (in_data.decl_len == '0) ? ppbf_pkg::LEN_W'(1) : in_data.decl_len;
    if (32'(len_nz) > MAX_PACKET_BYTES) begin
      len_clamped = ppbf_pkg::LEN_W'(MAX_PACKET_BYTES);
    end else begin
      len_clamped = len_nz;
    end
  end

  // Classify the byte and update the remaining count
  always_comb begin
    push          = in_valid && !in_stall;
    in_packet_nxt = in_packet_r;
    rem_nxt       = rem_r;
    if (!in_packet_r) begin
      last = (len_clamped == ppbf_pkg::LEN_W'(1));
    end else begin
      last = (rem_r == ppbf_pkg::LEN_W'(1));
    end
    if (push) begin
      in_packet_nxt = !last;
      rem_nxt       = in_packet_r ? rem_r - 1'b1 : len_clamped - 1'b1;
    end
    push_cmd.first = !in_packet_r;
    push_cmd.last  = last;
    push_cmd.data  = in_data.data_byte;
    push_cmd.len   = len_clamped;
    push_cmd.ifid  = in_data.if_index;
    push_cmd.sec   = in_data.ts_seconds;
    push_cmd.nsec  = in_data.ts_nanoseconds;
    push_cmd.dir   = in_data.direction;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      in_packet_r <= in_packet_nxt;
      rem_r       <= rem_nxt;
    end
  end

endmodule

### sv/ppbf_queue.sv
// Short command queue between the front and back ends of the framer.
// Register-based FIFO of ppbf_pkg::cmd_t entries; full and empty are registered-state flags.
module ppbf_queue #(
  parameter int DEPTH = ppbf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ppbf_pkg::cmd_t push_cmd,
  input  logic           pop,
  output ppbf_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppbf_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### sv/ppbf_usec.sv
// Timestamp conversion for the framer: seconds * 1000000 + nanoseconds / 1000.
// Two register stages; constants come from ppbf_pkg.
module ppbf_usec (
  input  logic        clk,
  input  logic [31:0] sec,
  input  logic [29:0] nsec,
  output logic [63:0] usec
);

  logic [51:0] sec_us_r;
  logic [60:0] ns_prod_r;
  logic [63:0] usec_r;

  // Stage 1: both constant multiplies; stage 2: add the quotient
  always_ff @(posedge clk) begin
    sec_us_r  <= 52'(sec) * 52'(ppbf_pkg::US_PER_SEC);
    ns_prod_r <= 61'(nsec) * 61'(ppbf_pkg::NS_RECIP);
    usec_r    <= 64'(sec_us_r) + 64'(ns_prod_r[60:ppbf_pkg::NS_SHIFT]);
  end

  assign usec = usec_r;

endmodule

### sv/ppbf_back.sv
// Back end of the framer: pops commands and sequences header, data and trailer bytes.
// Uses ppbf_usec for the timestamp and ppbf_pkg for types and format constants.
module ppbf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ppbf_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ppbf_pkg::out_item_t out_data
);

  ppbf_pkg::bk_state_t          state_r, state_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic                         advance;
  logic                         emit;
  ppbf_pkg::out_item_t          emit_item;
  logic                         out_valid_r;
  ppbf_pkg::out_item_t          out_r;

  // Per-packet fields latched from the first command
  logic [ppbf_pkg::LEN_W-1:0]   len_r;
  logic [15:0]                  ifid_r;
  logic [31:0]                  sec_r;
  logic [29:0]                  nsec_r;
  logic [1:0]                   dir_r;
  logic [7:0]                   first_data_r;
  logic                         first_last_r;
  logic [1:0]                   pad_r;
  logic [ppbf_pkg::TOTAL_W-1:0] total_r;
  logic [1:0]                   pad_new;
  logic [63:0]                  usec;
  logic [31:0]                  hdr_word;
  logic [31:0]                  trl_word;
  logic [3:0]                   trl_idx;
  logic [3:0]                   trl_start;
  logic                         latch;

  ppbf_usec u_usec (
    .clk  (clk),
    .sec  (sec_r),
    .nsec (nsec_r),
    .usec (usec)
  );

  assign advance   = !out_valid_r || !out_stall;
  assign pad_new   = ~q_cmd.len[1:0] + 2'd1;
  assign trl_start = 4'(~{2'b00, pad_r} + 4'd1);
  assign trl_idx   = cnt_r[3:0];

  // Header word for the current byte position
  always_comb begin
    case (cnt_r[4:2])
      3'd0:    hdr_word = ppbf_pkg::BLOCK_TYPE_EPB;
      3'd1:    hdr_word = 32'(total_r);
      3'd2:    hdr_word = 32'(ifid_r);
      3'd3:    hdr_word = usec[63:32];
      3'd4:    hdr_word = usec[31:0];
      default: hdr_word = 32'(len_r);
    endcase
  end

  // Trailer word: flags option, flags value, then total length; indexes 13 to 15 are padding
  always_comb begin
    case (trl_idx[3:2])
      2'd0:    trl_word = {ppbf_pkg::OPT_FLAGS_LEN, ppbf_pkg::OPT_EPB_FLAGS};
      2'd1:    trl_word = 32'(dir_r);
      2'd2:    trl_word = 32'(total_r);
      default: trl_word = '0;
    endcase
  end

  // Sequencer: next state and byte to emit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    latch     = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    case (state_r)
      ppbf_pkg::BK_FETCH: begin
        if (advance && !q_empty) begin
          q_pop = 1'b1;
          if (q_cmd.first) begin
            latch     = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ppbf_pkg::BK_HDR;
          end else begin
            emit               = 1'b1;
            emit_item.out_byte = q_cmd.data;
            if (q_cmd.last) begin
              cnt_nxt   = {1'b0, trl_start};
              state_nxt = ppbf_pkg::BK_TRL;
            end
          end
        end
      end
      ppbf_pkg::BK_HDR: begin
        emit               = 1'b1;
        emit_item.out_byte = hdr_word[8*cnt_r[1:0] +: 8];
        if (advance) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == ppbf_pkg::HDR_LAST_IDX) begin
            state_nxt = ppbf_pkg::BK_FIRST;
          end
        end
      end
      ppbf_pkg::BK_FIRST: begin
        emit               = 1'b1;
        emit_item.out_byte = first_data_r;
        if (advance) begin
          if (first_last_r) begin
            cnt_nxt   = {1'b0, trl_start};
            state_nxt = ppbf_pkg::BK_TRL;
          end else begin
            state_nxt = ppbf_pkg::BK_FETCH;
          end
        end
      end
      ppbf_pkg::BK_TRL: begin
        emit                   = 1'b1;
        emit_item.out_byte     = trl_word[8*trl_idx[1:0] +: 8];
        emit_item.end_of_block = (trl_idx == ppbf_pkg::TRL_LAST_IDX);
        if (advance) begin
          cnt_nxt = {1'b0, trl_idx + 4'd1};
          if (trl_idx == ppbf_pkg::TRL_LAST_IDX) begin
            state_nxt = ppbf_pkg::BK_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ppbf_pkg::BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppbf_pkg::BK_FETCH;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  // Output register payload and per-packet fields
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= emit_item;
    end
    if (latch) begin
      len_r        <= q_cmd.len;
      ifid_r       <= q_cmd.ifid;
      sec_r        <= q_cmd.sec;
      nsec_r       <= q_cmd.nsec;
      dir_r        <= q_cmd.dir;
      first_data_r <= q_cmd.data;
      first_last_r <= q_cmd.last;
      pad_r        <= pad_new;
      total_r      <= ppbf_pkg::BLOCK_OVERHEAD + ppbf_pkg::TOTAL_W'(q_cmd.len)
                      + ppbf_pkg::TOTAL_W'(pad_new);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/pcapng_packet_block_framer.sv
// Top level of the pcapng enhanced packet block framer.
// Instantiates ppbf_front, ppbf_queue and ppbf_back; types from ppbf_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry captured packet bytes, one per transfer.
//   On a packet's first byte the length, interface index, timestamp and
//   direction are sampled; later bytes use only data_byte.
//   out_valid/out_stall/out_data carry the block stream, one byte per
//   transfer, end_of_block high on the last byte of each block.
//   A first byte produces a 28-byte header and then the byte; the last byte
//   of a packet is followed by 0-3 pad bytes and a 12-byte trailer.
//   Path: a data byte is registered in the queue and then in the output
//   register; a first byte's header follows the fetch that latches its fields.
//   Throughput: one output byte per cycle while out_stall is low; data
//   bytes pass at one per cycle. Per packet the sequencer spends an idle
//   fetch, the header and the trailer; meanwhile the 4-entry queue fills
//   and in_stall rises, as it does when out_stall holds the output byte.
//   Reset (rst_n low, synchronous) empties the queue and the output register
//   and drops any partly framed packet.
module pcapng_packet_block_framer #(
  parameter int MAX_PACKET_BYTES = ppbf_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppbf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ppbf_pkg::out_item_t out_data
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  ppbf_pkg::cmd_t push_cmd;
  ppbf_pkg::cmd_t pop_cmd;

  assign in_stall = q_full;

  ppbf_front #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ppbf_queue #(
    .DEPTH (ppbf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  ppbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### bench/tb_pcapng_packet_block_framer.sv
// Self-checking bench for pcapng_packet_block_framer.
// Depends on ppbf_pkg and the framer RTL. Predicts every byte of each enhanced
// packet block and checks the output stream under random input idle and output stall.
module tb_pcapng_packet_block_framer;

  localparam int MAX_LEN = ppbf_pkg::DEF_MAX_PACKET_BYTES;
  localparam int IN_W    = $bits(ppbf_pkg::in_item_t);

  // Block byte predictor plus the queue of bytes still owed by the framer
  class epb_scoreboard;
    ppbf_pkg::out_item_t expected_bytes[$];
    int          mismatches;
    logic [13:0] bytes_left;
    logic        in_block;
    logic [15:0] total_len;
    logic [1:0]  pad_len;
    logic [1:0]  dir_code;

    function new();
      mismatches = 0;
      bytes_left = '0;
      in_block   = 1'b0;
      total_len  = '0;
      pad_len    = '0;
      dir_code   = '0;
    endfunction

    function void emit_byte(logic [7:0] b, logic eob);
      ppbf_pkg::out_item_t item;
      item.out_byte     = b;
      item.end_of_block = eob;
      expected_bytes.push_back(item);
    endfunction

    // little-endian field, eob on its last byte when it closes the block
    function void emit_le(int count, logic [63:0] value, logic last);
      for (int i = 0; i < count; i++) begin
        emit_byte(value[7:0], last && (i == count - 1));
        value = value >> 8;
      end
    endfunction

    function void emit_trailer();
      for (int i = 0; i < pad_len; i++) emit_byte(8'h00, 1'b0);
      emit_le(2, 64'(ppbf_pkg::OPT_EPB_FLAGS), 1'b0);
      emit_le(2, 64'(ppbf_pkg::OPT_FLAGS_LEN), 1'b0);
      emit_le(4, {62'd0, dir_code}, 1'b0);
      emit_le(4, 64'(total_len), 1'b1);
      in_block   = 1'b0;
      bytes_left = '0;
    endfunction

    // one accepted packet byte
    function void note_packet_byte(ppbf_pkg::in_item_t it);
      logic [15:0] len;
      logic [63:0] usec;
      if (!in_block) begin
        len = 16'(it.decl_len);
        if (len == 16'd0) len = 16'd1;
        if (len > 16'(MAX_LEN)) len = 16'(MAX_LEN);
        dir_code  = it.direction;
        pad_len   = 2'd0 - len[1:0];
        total_len = ppbf_pkg::BLOCK_OVERHEAD + len + 16'(pad_len);
        usec = 64'(it.ts_seconds) * 64'd1_000_000 + 64'(it.ts_nanoseconds / 30'd1000);
        emit_le(4, 64'(ppbf_pkg::BLOCK_TYPE_EPB), 1'b0);
        emit_le(4, 64'(total_len), 1'b0);
        emit_le(4, 64'(it.if_index), 1'b0);
        emit_le(4, usec >> 32, 1'b0);
        emit_le(4, {32'd0, usec[31:0]}, 1'b0);
        emit_le(4, 64'(len), 1'b0);
        emit_le(4, 64'(len), 1'b0);
        emit_byte(it.data_byte, 1'b0);
        bytes_left = 14'(len - 16'd1);
        in_block   = 1'b1;
        if (bytes_left == '0) emit_trailer();
      end else begin
        // later bytes: only data_byte matters
        emit_byte(it.data_byte, 1'b0);
        if (bytes_left != '0) bytes_left = bytes_left - 14'd1;
        if (bytes_left == '0) emit_trailer();
      end
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch on %s at %0t: got 0x%02h, expected 0x%02h", what, $realtime,
               got, want);
      mismatches++;
    endtask

    // one accepted output byte against the oldest prediction
    task check_block_byte(ppbf_pkg::out_item_t got);
      ppbf_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        report("unexpected byte", got.out_byte, 8'h00);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
      if (got.end_of_block !== want.end_of_block)
        report("end_of_block", 8'(got.end_of_block), 8'(want.end_of_block));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ppbf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ppbf_pkg::out_item_t out_data;
  logic                steady = 1'b0;  // high: neither side idles
  epb_scoreboard       board;

  pcapng_packet_block_framer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Random output backpressure
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 36);
  end

  // Output transfer happens at the next rising edge; sample at the falling edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_block_byte(out_data);
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_byte(input ppbf_pkg::in_item_t item);
    logic stalled;
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    board.note_packet_byte(item);
  endtask

  // First byte with the given header fields, then count-1 bytes whose
  // non-data fields are random noise
  task automatic send_packet(input logic [13:0] len_field, input logic [7:0] first_data,
                             input logic [15:0] ifid, input logic [31:0] sec,
                             input logic [29:0] nsec, input logic [1:0] dir, input int count);
    ppbf_pkg::in_item_t item;
    item.data_byte      = first_data;
    item.decl_len       = len_field;
    item.if_index       = ifid;
    item.ts_seconds     = sec;
    item.ts_nanoseconds = nsec;
    item.direction      = dir;
    send_byte(item);
    for (int i = 1; i < count; i++) begin
      item = IN_W'({$urandom, $urandom, $urandom, $urandom});
      send_byte(item);
    end
  endtask

  initial begin
    int          sent;
    int          pick;
    logic [13:0] len;
    logic [29:0] nsec;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte packet with interface, seconds, nanoseconds and direction at their largest in-range values
    send_packet(14'd1, 8'hff, 16'hffff, 32'hffff_ffff, 30'd999_999_999, 2'd3, 1);
    // zero length is framed as one byte
    send_packet(14'd0, 8'h00, 16'h0000, 32'd0, 30'd0, 2'd0, 1);
    // nanoseconds above one second used as given
    send_packet(14'd1, 8'h5a, 16'h8001, 32'h8000_0000, 30'h3fff_ffff, 2'd1, 1);
    // each padding amount
    for (int n = 2; n <= 5; n++)
      send_packet(14'(n), 8'($urandom), 16'($urandom), $urandom,
                  30'($urandom_range(999_999_999)), 2'(n), n);

    // random well-formed packets, mostly short, a middle stretch with no idling
    sent = 0;
    while (sent < 180) begin
      pick = $urandom_range(99);
      if (pick < 8) len = 14'd0;
      else if (pick < 75) len = 14'($urandom_range(8, 1));
      else len = 14'($urandom_range(48, 9));
      if ($urandom_range(9) == 0) nsec = 30'($urandom);
      else nsec = 30'($urandom_range(999_999_999));
      steady <= (sent >= 80 && sent < 130);
      send_packet(len, 8'($urandom), 16'($urandom), $urandom, nsec, 2'($urandom),
                  (len == 14'd0) ? 1 : int'(len));
      sent += (len == 14'd0) ? 1 : int'(len);
    end

    steady <= 1'b0;
    send_packet(14'd3, 8'($urandom), 16'($urandom), $urandom, 30'd0, 2'd2, 3);

    in_valid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### pcapng_packet_block_framer.f
sv/ppbf_pkg.sv
sv/ppbf_front.sv
sv/ppbf_queue.sv
sv/ppbf_usec.sv
sv/ppbf_back.sv
sv/pcapng_packet_block_framer.sv
bench/tb_pcapng_packet_block_framer.sv
